FILE: sv/rrd_pkg.sv
package rrd_pkg;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic [30:0]        eta;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               total_reflect;
  } out_item_t;

  localparam logic OP_REFLECT = 1'b0;
  localparam logic OP_REFRACT = 1'b1;

  // Item handed from front to back: operands plus the scaled, saturated dot product.
  typedef struct packed {
    logic               opcode;
    logic signed [31:0] w0;
    logic signed [31:0] w1;
    logic signed [31:0] w2;
    logic signed [31:0] n0;
    logic signed [31:0] n1;
    logic signed [31:0] n2;
    logic [30:0]        eta;
    logic signed [31:0] f;
  } work_t;

  localparam int SQ_STEPS = 32;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sh7FFFFFFF) return 32'sh7FFFFFFF;
    else if (v < -72'sh80000000) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

FILE: sv/reflect_refract_direction_core.sv
// Channel  | Handshake       | Payload
// command  | start / busy    | cmd    (rrd_pkg::in_item_t)
// result   | done (strobe)   | result (rrd_pkg::out_item_t)
//
// One item per cycle. A command reaches its result through 2 front stages,
// the queue, 4 back stages ahead of the root, 32 root stages and 2 output
// stages; the root pipeline sets the latency.
// Synchronous reset clears all valid flags; busy stays low since the
// pipeline never stalls (the receiver cannot stall) and the queue drains
// every cycle.
module reflect_refract_direction_core #(
  parameter int FRAC_BITS = 28
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  rrd_pkg::in_item_t  cmd,
  output logic               done,
  output rrd_pkg::out_item_t result
);

  logic           fv, qne;
  rrd_pkg::work_t fw, qw;

  assign busy = 1'b0;

  rrd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .in_item(cmd),
    .out_valid(fv), .out_work(fw)
  );

  rrd_queue #(.DEPTH(4)) u_queue (
    .clk(clk), .rst(rst), .push(fv), .push_data(fw),
    .pop(qne), .not_empty(qne), .pop_data(qw)
  );

  rrd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .in_valid(qne), .in_work(qw),
    .out_valid(done), .out_item(result)
  );

endmodule

FILE: sv/rrd_front.sv
// Front: dot product f = w.N over two registered stages.
module rrd_front #(
  parameter int FRAC_BITS = 28
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  rrd_pkg::in_item_t in_item,
  output logic              out_valid,
  output rrd_pkg::work_t    out_work
);

  logic              v1;
  rrd_pkg::in_item_t it1;
  logic signed [63:0] p0, p1, p2;

  // stage 1: three products
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= in_valid;
    it1 <= in_item;
    p0 <= 64'(in_item.dir_x) * 64'(in_item.normal_x);
    p1 <= 64'(in_item.dir_y) * 64'(in_item.normal_y);
    p2 <= 64'(in_item.dir_z) * 64'(in_item.normal_z);
  end

  // stage 2: exact sum, floor scale, saturate
  logic signed [71:0] sum;
  assign sum = (72'(p0) + 72'(p1) + 72'(p2)) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= v1;
    out_work.opcode <= it1.opcode;
    out_work.w0 <= it1.dir_x;
    out_work.w1 <= it1.dir_y;
    out_work.w2 <= it1.dir_z;
    out_work.n0 <= it1.normal_x;
    out_work.n1 <= it1.normal_y;
    out_work.n2 <= it1.normal_z;
    out_work.eta <= it1.eta;
    out_work.f <= rrd_pkg::sat32(sum);
  end

endmodule

FILE: sv/rrd_queue.sv
// Short FIFO between front and back.
module rrd_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rrd_pkg::work_t push_data,
  input  logic           pop,
  output logic           not_empty,
  output rrd_pkg::work_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rrd_pkg::work_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;

  assign not_empty = (cnt != '0);
  assign pop_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop) rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

FILE: sv/rrd_back.sv
// Back: refraction terms, pipelined square root, component assembly.
module rrd_back #(
  parameter int FRAC_BITS = 28
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  rrd_pkg::work_t     in_work,
  output logic               out_valid,
  output rrd_pkg::out_item_t out_item
);

  localparam int N = rrd_pkg::SQ_STEPS;
  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

  // stage A: f*f, eta*eta, f*N
  logic                 va;
  rrd_pkg::work_t       wa;
  logic signed [63:0]   ff, ee, fn0, fn1, fn2;
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else va <= in_valid;
    wa <= in_work;
    ff <= 64'(in_work.f) * 64'(in_work.f);
    ee <= $signed({33'd0, in_work.eta}) * $signed({33'd0, in_work.eta});
    fn0 <= 64'(in_work.f) * 64'(in_work.n0);
    fn1 <= 64'(in_work.f) * 64'(in_work.n1);
    fn2 <= 64'(in_work.f) * 64'(in_work.n2);
  end

  // stage B: g, e2, reflect and difference terms
  logic                 vb;
  rrd_pkg::work_t       wb;
  logic signed [31:0]   g, e2, r0, r1, r2, d0, d1, d2;
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else vb <= va;
    wb <= wa;
    g  <= rrd_pkg::sat32(72'(ONE) - 72'(ff >>> FRAC_BITS));
    e2 <= rrd_pkg::sat32(72'(ee >>> FRAC_BITS));
    r0 <= rrd_pkg::sat32(72'(wa.w0) - 72'(fn0 >>> (FRAC_BITS - 1)));
    r1 <= rrd_pkg::sat32(72'(wa.w1) - 72'(fn1 >>> (FRAC_BITS - 1)));
    r2 <= rrd_pkg::sat32(72'(wa.w2) - 72'(fn2 >>> (FRAC_BITS - 1)));
    d0 <= rrd_pkg::sat32(72'(wa.w0) - 72'(fn0 >>> FRAC_BITS));
    d1 <= rrd_pkg::sat32(72'(wa.w1) - 72'(fn1 >>> FRAC_BITS));
    d2 <= rrd_pkg::sat32(72'(wa.w2) - 72'(fn2 >>> FRAC_BITS));
  end

  // stage C: e2*g product
  logic                 vc;
  rrd_pkg::work_t       wc;
  logic signed [31:0]   rc0, rc1, rc2, dc0, dc1, dc2;
  logic signed [63:0]   eg;
  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else vc <= vb;
    wc <= wb;
    rc0 <= r0; rc1 <= r1; rc2 <= r2;
    dc0 <= d0; dc1 <= d1; dc2 <= d2;
    eg <= 64'(e2) * 64'(g);
  end

  // stage D: k, reflection decision, root operand
  typedef struct packed {
    logic               opcode;
    logic               tir;
    logic signed [31:0] n0, n1, n2;
    logic [30:0]        eta;
    logic signed [31:0] r0, r1, r2, d0, d1, d2;
  } carry_t;

  logic signed [64:0] k;
  assign k = 65'(ONE) - 65'(eg >>> FRAC_BITS);

  logic         vs   [N+1];
  carry_t       cs   [N+1];
  logic [63:0]  sx   [N+1];
  logic [63:0]  sres [N+1];

  always_ff @(posedge clk) begin
    logic signed [31:0] ks;
    ks = rrd_pkg::sat32(72'(k));
    if (rst) vs[0] <= 1'b0;
    else vs[0] <= vc;
    cs[0].opcode <= wc.opcode;
    cs[0].tir    <= (wc.opcode == rrd_pkg::OP_REFRACT) && k[64];
    cs[0].n0 <= wc.n0; cs[0].n1 <= wc.n1; cs[0].n2 <= wc.n2;
    cs[0].eta <= wc.eta;
    cs[0].r0 <= rc0; cs[0].r1 <= rc1; cs[0].r2 <= rc2;
    cs[0].d0 <= dc0; cs[0].d1 <= dc1; cs[0].d2 <= dc2;
    sx[0]   <= 64'(ks) << FRAC_BITS;
    sres[0] <= '0;
  end

  // square root: one restoring step per stage
  for (genvar i = 0; i < N; i++) begin : g_root
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] trial;
    assign trial = sres[i] + BIT;
    always_ff @(posedge clk) begin
      if (rst) vs[i+1] <= 1'b0;
      else vs[i+1] <= vs[i];
      cs[i+1] <= cs[i];
      if (sx[i] >= trial) begin
        sx[i+1]   <= sx[i] - trial;
        sres[i+1] <= (sres[i] >> 1) + BIT;
      end else begin
        sx[i+1]   <= sx[i];
        sres[i+1] <= sres[i] >> 1;
      end
    end
  end

  // stage E: eta*d and s*N products
  logic               ve;
  carry_t             ce;
  logic signed [63:0] ed0, ed1, ed2, sn0, sn1, sn2;
  logic signed [32:0] s33;
  assign s33 = $signed({1'b0, sres[N][31:0]});
  always_ff @(posedge clk) begin
    if (rst) ve <= 1'b0;
    else ve <= vs[N];
    ce <= cs[N];
    ed0 <= $signed({33'd0, cs[N].eta}) * 64'(cs[N].d0);
    ed1 <= $signed({33'd0, cs[N].eta}) * 64'(cs[N].d1);
    ed2 <= $signed({33'd0, cs[N].eta}) * 64'(cs[N].d2);
    sn0 <= 64'(s33) * 64'(cs[N].n0);
    sn1 <= 64'(s33) * 64'(cs[N].n1);
    sn2 <= 64'(s33) * 64'(cs[N].n2);
  end

  // stage F: select and saturate
  logic refl;
  assign refl = (ce.opcode == rrd_pkg::OP_REFLECT) || ce.tir;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= ve;
    out_item.total_reflect <= ce.tir;
    if (refl) begin
      out_item.out_x <= ce.r0;
      out_item.out_y <= ce.r1;
      out_item.out_z <= ce.r2;
    end else begin
      out_item.out_x <= rrd_pkg::sat32(72'(ed0 >>> FRAC_BITS) - 72'(sn0 >>> FRAC_BITS));
      out_item.out_y <= rrd_pkg::sat32(72'(ed1 >>> FRAC_BITS) - 72'(sn1 >>> FRAC_BITS));
      out_item.out_z <= rrd_pkg::sat32(72'(ed2 >>> FRAC_BITS) - 72'(sn2 >>> FRAC_BITS));
    end
  end

endmodule

FILE: sv/rrd_checker.sv
module rrd_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input rrd_pkg::out_item_t result
);

  // edges from a command transfer to its result transfer
  localparam int LATENCY = 41;

  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  a_quiet_after_reset: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("result right after reset");
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("result missing after command transfer");
  a_tir_sign: assert property (@(posedge clk) disable iff (rst)
    done && result.total_reflect |-> !$isunknown(result.out_x))
    else $error("reflection result unknown");

endmodule

bind reflect_refract_direction_core rrd_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);

FILE: dv/tb_reflect_refract_direction_core.sv
module tb_reflect_refract_direction_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int      FB       = 28;
  localparam longint  ONE      = longint'(1) << FB;
  localparam int      N_RANDOM = 1130;
  localparam longint  LIMIT    = 400000;
  localparam int      DRAIN    = 80;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  rrd_pkg::in_item_t  cmd = '0;
  logic               done;
  rrd_pkg::out_item_t result;

  typedef struct {
    rrd_pkg::in_item_t  cmd;
    bit                 known;
    rrd_pkg::out_item_t want;
  } vector_t;

  rrd_pkg::out_item_t expected_dirs[$];
  vector_t   vectors[$];
  int        errors = 0;
  longint    cycles = 0;
  bit        burst = 1'b0;

  reflect_refract_direction_core #(.FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .result(result)
  );

  always #2 clk = ~clk;

  // Clamp to the signed 32-bit range
  function automatic longint clamp32(logic signed [71:0] v);
    if (v > 72'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (v < -72'sh80000000) return -64'sh80000000;
    return longint'(v);
  endfunction

  // Bitwise integer square root, 32 steps
  function automatic longint unsigned int_root(longint unsigned x);
    longint unsigned res = 0;
    longint unsigned bitv = longint'(1) << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Expected bent/mirrored direction for one command
  function automatic rrd_pkg::out_item_t predict_direction(rrd_pkg::in_item_t c);
    longint w[3], n[3], r[3];
    longint f, f2, g, e2, k, s, d;
    longint eta;
    logic signed [71:0] acc;
    logic tir;
    rrd_pkg::out_item_t o;
    w[0] = c.dir_x;    w[1] = c.dir_y;    w[2] = c.dir_z;
    n[0] = c.normal_x; n[1] = c.normal_y; n[2] = c.normal_z;
    eta = longint'({33'd0, c.eta});
    acc = 0;
    for (int i = 0; i < 3; i++) acc += 72'(w[i] * n[i]);
    f = clamp32(acc >>> FB);
    tir = 1'b0;
    if (c.opcode == rrd_pkg::OP_REFRACT) begin
      f2 = (f * f) >>> FB;
      g  = clamp32(72'(ONE - f2));
      e2 = clamp32(72'((eta * eta) >>> FB));
      k  = ONE - ((e2 * g) >>> FB);
      tir = (k < 0);
    end
    if (c.opcode == rrd_pkg::OP_REFLECT || tir) begin
      for (int i = 0; i < 3; i++)
        r[i] = clamp32(72'(w[i] - ((f * n[i]) >>> (FB - 1))));
    end else begin
      s = longint'(int_root(longint'(clamp32(72'(k))) << FB));
      for (int i = 0; i < 3; i++) begin
        d = clamp32(72'(w[i] - ((f * n[i]) >>> FB)));
        r[i] = clamp32(72'(((eta * d) >>> FB) - ((s * n[i]) >>> FB)));
      end
    end
    o.out_x = r[0][31:0];
    o.out_y = r[1][31:0];
    o.out_z = r[2][31:0];
    o.total_reflect = tir;
    return o;
  endfunction

  function automatic rrd_pkg::in_item_t mk(logic op, longint wx, longint wy, longint wz,
                                           longint nx, longint ny, longint nz,
                                           longint e);
    rrd_pkg::in_item_t c;
    c.opcode = op;
    c.dir_x = wx[31:0];    c.dir_y = wy[31:0];    c.dir_z = wz[31:0];
    c.normal_x = nx[31:0]; c.normal_y = ny[31:0]; c.normal_z = nz[31:0];
    c.eta = e[30:0];
    return c;
  endfunction

  function automatic void add_row(rrd_pkg::in_item_t c, bit known,
                                  rrd_pkg::out_item_t want);
    vector_t v;
    v.cmd = c;
    v.known = known;
    v.want = known ? want : predict_direction(c);
    vectors.push_back(v);
  endfunction

  // Random field: mostly near unit scale, sometimes full range
  function automatic longint rand_comp();
    if ($urandom_range(0, 3) == 0) return longint'($signed($urandom()));
    return longint'($urandom_range(0, 2 * ONE)) - ONE;
  endfunction

  function automatic rrd_pkg::in_item_t rand_cmd();
    longint e;
    e = ($urandom_range(0, 3) == 0) ? longint'($urandom() & 32'h7FFFFFFF)
                                    : longint'($urandom_range(0, 2 * ONE));
    return mk(1'($urandom_range(0, 1)), rand_comp(), rand_comp(), rand_comp(),
              rand_comp(), rand_comp(), rand_comp(), e);
  endfunction

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    rrd_pkg::out_item_t e;
    if (!rst && done) begin
      if (expected_dirs.size() == 0) begin
        $error("unexpected result %h", result);
        errors++;
      end else begin
        e = expected_dirs.pop_front();
        if (result.out_x !== e.out_x) begin
          $error("out_x exp %h got %h", e.out_x, result.out_x); errors++;
        end
        if (result.out_y !== e.out_y) begin
          $error("out_y exp %h got %h", e.out_y, result.out_y); errors++;
        end
        if (result.out_z !== e.out_z) begin
          $error("out_z exp %h got %h", e.out_z, result.out_z); errors++;
        end
        if (result.total_reflect !== e.total_reflect) begin
          $error("total_reflect exp %b got %b", e.total_reflect,
                 result.total_reflect);
          errors++;
        end
      end
    end
  end

  // One command transfer, with a random gap in front unless in a burst
  task automatic send_cmd(vector_t v);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= v.cmd;
    do @(posedge clk); while (busy);
    expected_dirs.push_back(v.want);
  endtask

  initial begin
    rrd_pkg::out_item_t z;
    vector_t v;
    z = '0;
    // Directed rows; typed results where obvious
    add_row(mk(rrd_pkg::OP_REFLECT, ONE, 0, 0, ONE, 0, 0, 0), 1,
            '{-32'sd268435456, 0, 0, 0});
    add_row(mk(rrd_pkg::OP_REFRACT, 0, 0, 0, 0, 0, ONE, 0), 1,
            '{0, 0, -32'sd268435456, 0});
    // total internal reflection: eta 2, grazing ray
    add_row(mk(rrd_pkg::OP_REFRACT, ONE, 0, 0, 0, ONE, 0, 2 * ONE), 1,
            '{32'sd268435456, 0, 0, 1'b1});
    // zero normal mirrors nothing
    add_row(mk(rrd_pkg::OP_REFLECT, 123, -456, 789, 0, 0, 0, 0), 1,
            '{123, -456, 789, 0});
    add_row(mk(rrd_pkg::OP_REFRACT, 0, 0, 0, 0, 0, 0, 0), 1, '{0, 0, 0, 0});
    // extremes that saturate intermediates, plus mid-range cases
    for (int op = 0; op < 2; op++) begin
      add_row(mk(1'(op), 64'sh7FFFFFFF, 64'sh7FFFFFFF, 64'sh7FFFFFFF,
                 64'sh7FFFFFFF, 64'sh7FFFFFFF, 64'sh7FFFFFFF, 64'sh7FFFFFFF), 0, z);
      add_row(mk(1'(op), -64'sh80000000, -64'sh80000000, -64'sh80000000,
                 -64'sh80000000, -64'sh80000000, -64'sh80000000, 0), 0, z);
      add_row(mk(1'(op), -64'sh80000000, 64'sh7FFFFFFF, -64'sh80000000,
                 64'sh7FFFFFFF, -64'sh80000000, 64'sh7FFFFFFF, 64'sh7FFFFFFF), 0, z);
      add_row(mk(1'(op), ONE, 0, 0, -ONE, 0, 0, ONE), 0, z);
      add_row(mk(1'(op), ONE / 2, -ONE / 2, ONE / 3, 0, 0, -ONE, ONE * 2 / 3), 0, z);
      add_row(mk(1'(op), 3 * ONE, 5 * ONE, -7 * ONE, 0, ONE, 0, 64'sh7FFFFFFF), 0, z);
      add_row(mk(1'(op), ONE, ONE, ONE, 4 * ONE, -4 * ONE, 4 * ONE, ONE / 2), 0, z);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (vectors[i]) send_cmd(vectors[i]);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) burst = ($urandom_range(0, 3) == 0);
      if (i == N_RANDOM / 2) begin
        start <= 1'b0;
        wait (expected_dirs.size() == 0);
        @(posedge clk);
      end
      v.cmd = rand_cmd();
      v.known = 0;
      v.want = predict_direction(v.cmd);
      send_cmd(v);
    end
    start <= 1'b0;

    wait (expected_dirs.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/rrd_pkg.sv
sv/rrd_front.sv
sv/rrd_queue.sv
sv/rrd_back.sv
sv/reflect_refract_direction_core.sv
sv/rrd_checker.sv
dv/tb_reflect_refract_direction_core.sv
